[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/crcfr_pkg.sv]
// ----------------------------------------------------------------------------
// crcfr_pkg
// types, codes and the crc byte update shared by the frame receiver
// ----------------------------------------------------------------------------
package crcfr_pkg;

  // stream widths
  localparam int unsigned TdataInW = 8;
  localparam int unsigned TdataOutW = 72;
  localparam int unsigned TuserOutW = 5;
  localparam int unsigned CfgIndexW = 8;
  localparam int unsigned CfgDataW = 16;

  // framing constants
  localparam logic [7:0] SYNC_FIRST = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [2:0] HDR_LAST_POS = 3'd5;

  // register indexes
  localparam logic [CfgIndexW-1:0] REG_MAX_PAYLOAD_LENGTH = 8'd0;
  localparam logic [CfgIndexW-1:0] REG_HOST_COMMAND_TYPE = 8'd1;
  localparam logic [CfgIndexW-1:0] REG_STATUS_TYPE = 8'd2;
  localparam logic [CfgIndexW-1:0] REG_STATUS_MIN_LENGTH = 8'd3;

  // frame status codes
  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_BAD_CRC = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // dispatch kind codes
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // configuration register set
  typedef struct packed {
    logic [15:0] max_payload_length;
    logic [7:0]  host_command_type;
    logic [7:0]  status_type;
    logic [15:0] status_min_length;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        frame_end;
    logic [1:0]  frame_status;
    logic [1:0]  frame_kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_sequence;
    logic [15:0] frame_length;
  } res_t;

  // reflected ccitt crc, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] e;
    logic [7:0] f;
    e = crc[7:0] ^ b;
    f = e ^ {e[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {f, 8'h00} ^ {5'b00000, f, 3'b000} ^ {12'h000, f[7:4]};
  endfunction

endpackage

[hw/rtl/crcfr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// crcfr_cfg_regs
// configuration registers written through the index/data channel
// ----------------------------------------------------------------------------
module crcfr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [crcfr_pkg::CfgIndexW-1:0]      index_i,
  input  logic [crcfr_pkg::CfgDataW-1:0]       data_i,
  output crcfr_pkg::cfg_t                      cfg_o
);

  crcfr_pkg::cfg_t cfg_q, cfg_d;

  // register decode, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (index_i)
        crcfr_pkg::REG_MAX_PAYLOAD_LENGTH: cfg_d.max_payload_length = data_i;
        crcfr_pkg::REG_HOST_COMMAND_TYPE:  cfg_d.host_command_type = data_i[7:0];
        crcfr_pkg::REG_STATUS_TYPE:        cfg_d.status_type = data_i[7:0];
        crcfr_pkg::REG_STATUS_MIN_LENGTH:  cfg_d.status_min_length = data_i;
        default: ;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload_length <= 16'd256;
      cfg_q.host_command_type <= 8'd1;
      cfg_q.status_type <= 8'd2;
      cfg_q.status_min_length <= 16'd8;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/crcfr_parser.sv]
// ----------------------------------------------------------------------------
// crcfr_parser
// sync hunt, header capture, payload streaming and crc check, one byte a step
// ----------------------------------------------------------------------------
module crcfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  crcfr_pkg::cfg_t  cfg_i,
  output crcfr_pkg::res_t  res_o
);

  typedef enum logic [2:0] {
    PhHunt0 = 3'd0,
    PhHunt1 = 3'd1,
    PhHdr   = 3'd2,
    PhPay   = 3'd3,
    PhCrc   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  hdr_type_q, hdr_type_d;
  logic [7:0]  hdr_flags_q, hdr_flags_d;
  logic [15:0] hdr_len_q, hdr_len_d;
  logic [15:0] hdr_seq_q, hdr_seq_d;
  logic [15:0] pay_cnt_q, pay_cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        crc_cnt_q, crc_cnt_d;

  logic [15:0] crc_next;
  logic [16:0] cnt_inc;
  logic        show_hdr;

  assign crc_next = crcfr_pkg::crc_feed(crc_q, byte_i);
  assign cnt_inc = {1'b0, pay_cnt_q} + 17'd1;

  // next state and result for the byte in the input register
  always_comb begin
    phase_d = phase_q;
    hdr_pos_d = hdr_pos_q;
    hdr_type_d = hdr_type_q;
    hdr_flags_d = hdr_flags_q;
    hdr_len_d = hdr_len_q;
    hdr_seq_d = hdr_seq_q;
    pay_cnt_d = pay_cnt_q;
    crc_d = crc_q;
    crc_lo_d = crc_lo_q;
    crc_cnt_d = crc_cnt_q;
    res_o = '0;
    show_hdr = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PhHunt1: begin
          if (byte_i == crcfr_pkg::SYNC_SECOND) begin
            hdr_pos_d = '0;
            crc_d = crcfr_pkg::CRC_SEED;
            phase_d = PhHdr;
          end else if (byte_i != crcfr_pkg::SYNC_FIRST) begin
            phase_d = PhHunt0;
          end
        end
        PhHdr: begin
          crc_d = crc_next;
          unique case (hdr_pos_q)
            3'd0: hdr_type_d = byte_i;
            3'd1: hdr_flags_d = byte_i;
            3'd2: hdr_len_d = {hdr_len_q[15:8], byte_i};
            3'd3: hdr_len_d = {byte_i, hdr_len_q[7:0]};
            3'd4: hdr_seq_d = {hdr_seq_q[15:8], byte_i};
            default: hdr_seq_d = {byte_i, hdr_seq_q[7:0]};
          endcase
          if (hdr_pos_q >= crcfr_pkg::HDR_LAST_POS) begin
            hdr_pos_d = '0;
            pay_cnt_d = '0;
            crc_cnt_d = 1'b0;
            if (hdr_len_q > cfg_i.max_payload_length) begin
              res_o.frame_end = 1'b1;
              res_o.frame_status = crcfr_pkg::STATUS_TOO_LONG;
              show_hdr = 1'b1;
              phase_d = PhHunt0;
            end else if (hdr_len_q == '0) begin
              phase_d = PhCrc;
            end else begin
              phase_d = PhPay;
            end
          end else begin
            hdr_pos_d = hdr_pos_q + 3'd1;
          end
        end
        PhPay: begin
          crc_d = crc_next;
          res_o.payload_valid = 1'b1;
          res_o.payload_byte = byte_i;
          res_o.payload_index = pay_cnt_q;
          show_hdr = 1'b1;
          if (cnt_inc >= {1'b0, hdr_len_q}) begin
            phase_d = PhCrc;
            crc_cnt_d = 1'b0;
          end
          pay_cnt_d = cnt_inc[15:0];
        end
        PhCrc: begin
          if (!crc_cnt_q) begin
            crc_lo_d = byte_i;
            crc_cnt_d = 1'b1;
          end else begin
            crc_cnt_d = 1'b0;
            res_o.frame_end = 1'b1;
            show_hdr = 1'b1;
            phase_d = PhHunt0;
            if ({byte_i, crc_lo_q} == crc_q) begin
              res_o.frame_status = crcfr_pkg::STATUS_GOOD;
              if (hdr_type_q == cfg_i.host_command_type) begin
                res_o.frame_kind = crcfr_pkg::KIND_HOST;
              end else if (hdr_type_q == cfg_i.status_type &&
                           hdr_len_q >= cfg_i.status_min_length) begin
                res_o.frame_kind = crcfr_pkg::KIND_STATUS;
              end
            end else begin
              res_o.frame_status = crcfr_pkg::STATUS_BAD_CRC;
            end
          end
        end
        default: begin
          phase_d = (byte_i == crcfr_pkg::SYNC_FIRST) ? PhHunt1 : PhHunt0;
        end
      endcase
    end
    // header fields as they stand after this byte
    if (show_hdr) begin
      res_o.frame_type = hdr_type_d;
      res_o.frame_flags = hdr_flags_d;
      res_o.frame_sequence = hdr_seq_d;
      res_o.frame_length = hdr_len_d;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt0;
      hdr_pos_q <= '0;
      hdr_type_q <= '0;
      hdr_flags_q <= '0;
      hdr_len_q <= '0;
      hdr_seq_q <= '0;
      pay_cnt_q <= '0;
      crc_q <= crcfr_pkg::CRC_SEED;
      crc_lo_q <= '0;
      crc_cnt_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      hdr_pos_q <= hdr_pos_d;
      hdr_type_q <= hdr_type_d;
      hdr_flags_q <= hdr_flags_d;
      hdr_len_q <= hdr_len_d;
      hdr_seq_q <= hdr_seq_d;
      pay_cnt_q <= pay_cnt_d;
      crc_q <= crc_d;
      crc_lo_q <= crc_lo_d;
      crc_cnt_q <= crc_cnt_d;
    end
  end

endmodule

[hw/rtl/crc_checked_frame_receiver_top.sv]
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_top
// sync/header/payload/crc16 deframer with streaming byte in, result word out
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the result stream does not stall
// and returns exactly one result word per byte, in order. Each byte passes an
// input register, one step of the parser (sync hunt, header capture, payload
// pass-through, reflected ccitt crc update and check) and the output register,
// from which its result word is offered; the per-byte crc update and parser
// step set the one-byte-per-cycle rate. The input register accepts a new byte
// while the output register holds a word not yet taken, if it is itself empty.
// Payload bytes are streamed before the crc verdict: discard them when the
// closing word reports a bad frame. Configuration writes are taken at any time
// but belong in idle periods.
module crc_checked_frame_receiver_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // byte input stream
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [crcfr_pkg::TdataInW-1:0]        s_axis_tdata_i,   // [7:0] rx_byte
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
  // [39:32] frame_flags, [55:40] frame_sequence, [71:56] frame_length
  output logic [crcfr_pkg::TdataOutW-1:0]       m_axis_tdata_o,
  // [0] payload_valid, [2:1] frame_status, [4:3] frame_kind
  output logic [crcfr_pkg::TuserOutW-1:0]       m_axis_tuser_o,
  output logic                                  m_axis_tlast_o,   // frame_end
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [crcfr_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [crcfr_pkg::CfgDataW-1:0]        cfg_data_i
);

  crcfr_pkg::cfg_t cfg;
  crcfr_pkg::res_t step_res;
  crcfr_pkg::res_t out_res_q;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  logic       in_take;
  logic       advance;

  assign cfg_ready_o = 1'b1;

  crcfr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i & cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  // handshake between input register and output register
  assign advance = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign in_take = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  crcfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_res_q <= step_res;
    end
  end

  // output packing
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o = out_res_q.frame_end;
  assign m_axis_tuser_o = {out_res_q.frame_kind, out_res_q.frame_status,
                           out_res_q.payload_valid};
  assign m_axis_tdata_o = {out_res_q.frame_length, out_res_q.frame_sequence,
                           out_res_q.frame_flags, out_res_q.frame_type,
                           out_res_q.payload_index, out_res_q.payload_byte};

endmodule

[hw/rtl/crcfr_checker.sv]
// ----------------------------------------------------------------------------
// crcfr_checker
// port-level checks on the result stream of the frame receiver
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crcfr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [crcfr_pkg::TdataOutW-1:0]       m_axis_tdata_o,
  input logic [crcfr_pkg::TuserOutW-1:0]       m_axis_tuser_o,
  input logic                                  m_axis_tlast_o
);

  logic                                              word_stall;
  logic [crcfr_pkg::TdataOutW+crcfr_pkg::TuserOutW:0] word_all;
  logic                                              pay_word;
  logic                                              mid_word;
  logic [3:0]                                        word_codes;
  logic                                              kind_word;
  logic                                              kind_ok;

  // views of the result word
  assign word_stall = m_axis_tvalid_o & ~m_axis_tready_i;
  assign word_all = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign pay_word = m_axis_tvalid_o & m_axis_tuser_o[0];
  assign mid_word = m_axis_tvalid_o & ~m_axis_tlast_o;
  assign word_codes = m_axis_tuser_o[4:1];
  assign kind_word = m_axis_tvalid_o & (m_axis_tuser_o[4:3] != crcfr_pkg::KIND_OTHER);
  assign kind_ok = (m_axis_tuser_o[2:1] == crcfr_pkg::STATUS_GOOD) &&
                   ((m_axis_tuser_o[4:3] == crcfr_pkg::KIND_HOST) ||
                    (m_axis_tuser_o[4:3] == crcfr_pkg::KIND_STATUS));

  // a stalled word holds its payload
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, word_stall |=> $stable(word_all), "stalled word changed")

  // a payload word never closes a frame
  `ASSERT_CLK(a_pay_last, clk_i, rst_ni, pay_word |-> !m_axis_tlast_o, "payload word ends frame")

  // status and kind stay zero away from frame end
  `ASSERT_CLK(a_codes_end, clk_i, rst_ni, mid_word |-> word_codes == '0, "code outside frame end")

  // a dispatch kind only follows a good crc
  `ASSERT_CLK(a_kind_good, clk_i, rst_ni, kind_word |-> kind_ok, "kind reported on a bad frame")

endmodule

bind crc_checked_frame_receiver_top crcfr_checker u_crcfr_checker (.*);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the crc checked frame receiver
// ----------------------------------------------------------------------------
// Feeds link bytes through the input stream and keeps a byte-level model of
// the sync hunt, header capture, payload pass-through and crc check. Every
// result word is compared with the oldest predicted word. Register sets are
// changed between traffic phases once all words are back; the traffic is
// mostly well-formed frames with random content plus noise, broken crcs and
// cut-off frames.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned REPORT_MAX = 10;
  // index past the register list, must be ignored
  localparam logic [crcfr_pkg::CfgIndexW-1:0] REG_SPARE = 8'd4;

  typedef enum logic [2:0] {
    HUNT_SYNC0,
    HUNT_SYNC1,
    IN_HEADER,
    IN_PAYLOAD,
    IN_CRC
  } parse_state_e;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready_o;
  logic [crcfr_pkg::TdataInW-1:0]       s_axis_tdata = '0;
  logic                                 m_axis_tvalid_o;
  logic                                 m_axis_tready = 1'b0;
  logic [crcfr_pkg::TdataOutW-1:0]      m_axis_tdata_o;
  logic [crcfr_pkg::TuserOutW-1:0]      m_axis_tuser_o;
  logic                                 m_axis_tlast_o;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready_o;
  logic [crcfr_pkg::CfgIndexW-1:0]      cfg_index = '0;
  logic [crcfr_pkg::CfgDataW-1:0]       cfg_data = '0;

  // stimulus and checking stores
  logic [7:0]      link_bytes[$];
  crcfr_pkg::res_t pending_results[$];
  int              mismatch_count = 0;
  int              result_count = 0;
  int              stall_cycles = 0;
  logic            in_took = 1'b0;

  // idling control shared by both stream sides
  bit no_idle = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  // register values as programmed, used to shape the traffic
  logic [15:0] cur_max = 16'd256;
  logic [7:0]  cur_host = 8'd1;
  logic [7:0]  cur_status = 8'd2;
  logic [15:0] cur_min = 16'd8;

  // deframer model state and its register copy
  parse_state_e ps = HUNT_SYNC0;
  logic [2:0]   hdr_pos = '0;
  logic [7:0]   hdr_type = '0;
  logic [7:0]   hdr_flags = '0;
  logic [15:0]  hdr_len = '0;
  logic [15:0]  hdr_seq = '0;
  logic [15:0]  pay_count = '0;
  logic [15:0]  crc_run = crcfr_pkg::CRC_SEED;
  logic [7:0]   crc_lo = '0;
  logic         crc_half = 1'b0;
  logic [15:0]  lim_max = 16'd256;
  logic [7:0]   typ_host = 8'd1;
  logic [7:0]   typ_status = 8'd2;
  logic [15:0]  lim_status = 16'd8;

  crc_checked_frame_receiver_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #5 clk = ~clk;

  // bitwise reflected ccitt update, poly 0x8408
  function automatic logic [15:0] ccitt_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
    end
    return r;
  endfunction

  // one parser step: advance the model and return the expected word
  function automatic crcfr_pkg::res_t deframe_byte(input logic [7:0] b);
    crcfr_pkg::res_t r;
    logic            show;
    logic [15:0]     rx_crc;
    r = '0;
    show = 1'b0;
    case (ps)
      HUNT_SYNC1: begin
        if (b == crcfr_pkg::SYNC_SECOND) begin
          hdr_pos = '0;
          crc_run = crcfr_pkg::CRC_SEED;
          ps = IN_HEADER;
        end else if (b != crcfr_pkg::SYNC_FIRST) begin
          ps = HUNT_SYNC0;
        end
      end
      IN_HEADER: begin
        crc_run = ccitt_step(crc_run, b);
        case (hdr_pos)
          3'd0: hdr_type = b;
          3'd1: hdr_flags = b;
          3'd2: hdr_len[7:0] = b;
          3'd3: hdr_len[15:8] = b;
          3'd4: hdr_seq[7:0] = b;
          default: hdr_seq[15:8] = b;
        endcase
        if (hdr_pos >= crcfr_pkg::HDR_LAST_POS) begin
          hdr_pos = '0;
          pay_count = '0;
          crc_half = 1'b0;
          if (hdr_len > lim_max) begin
            r.frame_end = 1'b1;
            r.frame_status = crcfr_pkg::STATUS_TOO_LONG;
            show = 1'b1;
            ps = HUNT_SYNC0;
          end else begin
            ps = (hdr_len == 16'd0) ? IN_CRC : IN_PAYLOAD;
          end
        end else begin
          hdr_pos = hdr_pos + 3'd1;
        end
      end
      IN_PAYLOAD: begin
        crc_run = ccitt_step(crc_run, b);
        r.payload_valid = 1'b1;
        r.payload_byte = b;
        r.payload_index = pay_count;
        show = 1'b1;
        if ({16'd0, pay_count} + 32'd1 >= {16'd0, hdr_len}) begin
          ps = IN_CRC;
          crc_half = 1'b0;
        end
        pay_count = pay_count + 16'd1;
      end
      IN_CRC: begin
        if (!crc_half) begin
          crc_lo = b;
          crc_half = 1'b1;
        end else begin
          rx_crc = {b, crc_lo};
          crc_half = 1'b0;
          r.frame_end = 1'b1;
          show = 1'b1;
          if (rx_crc == crc_run) begin
            r.frame_status = crcfr_pkg::STATUS_GOOD;
            if (hdr_type == typ_host) r.frame_kind = crcfr_pkg::KIND_HOST;
            else if (hdr_type == typ_status && hdr_len >= lim_status)
              r.frame_kind = crcfr_pkg::KIND_STATUS;
            else r.frame_kind = crcfr_pkg::KIND_OTHER;
          end else begin
            r.frame_status = crcfr_pkg::STATUS_BAD_CRC;
          end
          ps = HUNT_SYNC0;
        end
      end
      default: begin
        ps = (b == crcfr_pkg::SYNC_FIRST) ? HUNT_SYNC1 : HUNT_SYNC0;
      end
    endcase
    if (show) begin
      r.frame_type = hdr_type;
      r.frame_flags = hdr_flags;
      r.frame_sequence = hdr_seq;
      r.frame_length = hdr_len;
    end
    return r;
  endfunction

  function automatic string word_str(input crcfr_pkg::res_t r);
    return {$sformatf("pv=%0d byte=%02h idx=%04h end=%0d st=%0d kind=%0d ",
                      r.payload_valid, r.payload_byte, r.payload_index, r.frame_end,
                      r.frame_status, r.frame_kind),
            $sformatf("type=%02h flags=%02h seq=%04h len=%04h",
                      r.frame_type, r.frame_flags, r.frame_sequence, r.frame_length)};
  endfunction

  // byte source: a word stays offered until taken
  always @(negedge clk) begin : drive_link
    logic offer;
    if (rst_ni && (!s_axis_tvalid || in_took)) begin
      offer = (link_bytes.size() != 0) && (no_idle || $urandom_range(99) >= 7);
      if (offer) begin
        s_axis_tdata <= link_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink with random stalls and requested long hold-offs
  always @(negedge clk) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  // compare result words, predict on accepted bytes, track register writes
  always @(posedge clk) begin : check_results
    crcfr_pkg::res_t got;
    crcfr_pkg::res_t want;
    in_took <= s_axis_tvalid && s_axis_tready_o;
    if (m_axis_tvalid_o && m_axis_tready) begin
      got.payload_valid = m_axis_tuser_o[0];
      got.frame_status = m_axis_tuser_o[2:1];
      got.frame_kind = m_axis_tuser_o[4:3];
      got.frame_end = m_axis_tlast_o;
      got.payload_byte = m_axis_tdata_o[7:0];
      got.payload_index = m_axis_tdata_o[23:8];
      got.frame_type = m_axis_tdata_o[31:24];
      got.frame_flags = m_axis_tdata_o[39:32];
      got.frame_sequence = m_axis_tdata_o[55:40];
      got.frame_length = m_axis_tdata_o[71:56];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected word with nothing pending: %s", word_str(got));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch on word %0d", result_count);
            $display("  expected %s", word_str(want));
            $display("  actual   %s", word_str(got));
          end
        end
      end
      result_count++;
    end
    if (s_axis_tvalid && s_axis_tready_o)
      pending_results.push_back(deframe_byte(s_axis_tdata));
    if (cfg_valid && cfg_ready_o) begin
      case (cfg_index)
        crcfr_pkg::REG_MAX_PAYLOAD_LENGTH: lim_max = cfg_data;
        crcfr_pkg::REG_HOST_COMMAND_TYPE:  typ_host = cfg_data[7:0];
        crcfr_pkg::REG_STATUS_TYPE:        typ_status = cfg_data[7:0];
        crcfr_pkg::REG_STATUS_MIN_LENGTH:  lim_status = cfg_data;
        default: ;
      endcase
    end
    // watchdog on cycles with no handshake at all
    if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready) ||
        (cfg_valid && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [crcfr_pkg::CfgIndexW-1:0] idx,
                           input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
  endtask

  // full register set; upper data bits of byte registers carry junk
  task automatic program_regs(input logic [15:0] max_d, input logic [15:0] host_d,
                              input logic [15:0] status_d, input logic [15:0] min_d);
    write_reg(crcfr_pkg::REG_MAX_PAYLOAD_LENGTH, max_d);
    write_reg(crcfr_pkg::REG_HOST_COMMAND_TYPE, host_d);
    write_reg(crcfr_pkg::REG_STATUS_TYPE, status_d);
    write_reg(crcfr_pkg::REG_STATUS_MIN_LENGTH, min_d);
    write_reg(REG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_max = max_d;
    cur_host = host_d[7:0];
    cur_status = status_d[7:0];
    cur_min = min_d;
  endtask

  // wait until the block has handed back every word
  task automatic drain();
    @(posedge clk);
    while (link_bytes.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one frame: extra sync bytes, header, payload, crc; optionally cut short
  task automatic queue_frame(input logic [7:0] ftype, input logic [7:0] flags,
                             input logic [15:0] len, input logic [15:0] seq,
                             input int n_extra_sync, input bit bad_crc, input int cut);
    logic [7:0]  body[$];
    logic [15:0] crc;
    body = {ftype, flags, len[7:0], len[15:8], seq[7:0], seq[15:8]};
    // too-long frames stop after the header
    if (len <= cur_max) begin
      for (int i = 0; i < len; i++) body.push_back(8'($urandom));
      crc = crcfr_pkg::CRC_SEED;
      foreach (body[i]) crc = ccitt_step(crc, body[i]);
      if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
      body.push_back(crc[7:0]);
      body.push_back(crc[15:8]);
    end
    repeat (n_extra_sync) link_bytes.push_back(crcfr_pkg::SYNC_FIRST);
    link_bytes.push_back(crcfr_pkg::SYNC_FIRST);
    link_bytes.push_back(crcfr_pkg::SYNC_SECOND);
    foreach (body[i]) begin
      if (cut < 0 || i < cut) link_bytes.push_back(body[i]);
    end
  endtask

  // mostly frames with random content, some noise and broken frames
  task automatic random_traffic(input int n_bytes);
    int          start;
    int unsigned roll;
    int unsigned cap;
    logic [7:0]  ftype;
    logic [15:0] len;
    start = link_bytes.size();
    while (link_bytes.size() - start < n_bytes) begin
      roll = $urandom_range(99);
      if (roll < 6) begin
        repeat ($urandom_range(4, 1)) begin
          link_bytes.push_back(($urandom_range(3) == 0) ? crcfr_pkg::SYNC_FIRST
                                                         : 8'($urandom));
        end
      end else begin
        case ($urandom_range(2))
          0: ftype = cur_host;
          1: ftype = cur_status;
          default: ftype = 8'($urandom);
        endcase
        cap = ($urandom_range(99) < 5) ? 40 : 16;
        if (cur_max < cap) cap = cur_max;
        roll = $urandom_range(99);
        if (roll < 12 && cur_max != 16'hFFFF)
          len = 16'($urandom_range(65535, int'(cur_max) + 1));
        else if (roll < 22 && cur_min <= cap)
          len = cur_min;
        else
          len = 16'($urandom_range(cap, 0));
        queue_frame(ftype, 8'($urandom), len, 16'($urandom), $urandom_range(2, 0),
                    $urandom_range(99) < 15,
                    ($urandom_range(99) < 4) ? int'($urandom_range(6 + len, 1)) : -1);
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // reset register values: repeated sync with empty host frame, oversize
    // header, one-byte status frame with broken crc
    queue_frame(8'd1, 8'hFF, 16'd0, 16'hFFFF, 1, 1'b0, -1);
    queue_frame(8'h00, 8'h00, 16'hFFFF, 16'h0000, 0, 1'b0, -1);
    queue_frame(8'd2, 8'h5A, 16'd1, 16'hA5A5, 0, 1'b1, -1);
    drain();

    // no payload allowed, any status frame dispatched
    program_regs(16'd0, 16'hFF00, 16'h12FF, 16'd0);
    random_traffic(150);
    drain();

    // widest limit, shared type code, status never long enough; no idling
    no_idle = 1'b1;
    program_regs(16'hFFFF, 16'h005A, 16'hC35A, 16'hFFFF);
    random_traffic(170);
    drain();
    no_idle = 1'b0;

    // long sink hold-off while bytes keep coming, then a full pause
    program_regs(16'd24, 16'h00FF, 16'h0000, 16'd4);
    hold_req++;
    random_traffic(90);
    drain();
    random_traffic(80);
    drain();

    // random register set
    program_regs(16'($urandom_range(40, 8)), 16'($urandom), 16'($urandom),
                 16'($urandom_range(44, 0)));
    random_traffic(180);
    drain();

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
